### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sbcd_pkg.sv
`default_nettype none

package sbcd_pkg;

  // Default geometry of the directory.
  localparam int DEF_ENTRIES    = 128;
  localparam int DEF_COUNT_BITS = 8;

  // Request functions.
  localparam logic [2:0] FN_GET        = 3'd0;
  localparam logic [2:0] FN_READ       = 3'd1;
  localparam logic [2:0] FN_READ_DONE  = 3'd2;
  localparam logic [2:0] FN_RELEASE    = 3'd3;
  localparam logic [2:0] FN_MARK_DIRTY = 3'd4;

  // Response status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_SIZE      = 2'd2;
  localparam logic [1:0] ST_READ_FAIL = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] device;
    logic [31:0] sector;
    logic        size_ok;
    logic [6:0]  entry;
    logic        io_ok;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  slot;
    logic        fresh;
    logic        read_request;
    logic        write_request;
    logic [15:0] io_device;
    logic [31:0] io_sector;
    logic        wake_waiters;
  } rsp_t;

  // Commands to the tag store.
  typedef struct packed {
    logic scan;
    logic wr;
  } tag_ctl_t;

  // Status back from the tag store.
  typedef struct packed {
    logic done;
    logic hit;
  } tag_stat_t;

endpackage

`default_nettype wire

### hw/rtl/sbcd_tags.sv
`default_nettype none
`include "assert_macros.svh"

module sbcd_tags #(
  parameter int Entries = sbcd_pkg::DEF_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sbcd_pkg::tag_ctl_t           ctl,
  input  logic [15:0]                  key_dev,
  input  logic [31:0]                  key_sec,
  input  logic [$clog2(Entries)-1:0]   addr,
  output sbcd_pkg::tag_stat_t          stat,
  output logic [$clog2(Entries)-1:0]   hit_idx,
  output logic [15:0]                  rd_dev,
  output logic [31:0]                  rd_sec
);

  localparam int IDX = $clog2(Entries);
  localparam int CW  = IDX + 1;

  logic [47:0]    tag_mem [Entries];
  logic [47:0]    rd_data;
  logic [47:0]    key;
  logic           scan_on;
  logic           cmp_v;
  logic [CW-1:0]  iss;
  logic [IDX-1:0] cmp_idx;
  logic [IDX-1:0] rd_addr;
  logic           match;
  logic           last;

  // The scan owns the read port while it runs.
  assign rd_addr = scan_on ? iss[IDX-1:0] : addr;

  // Tag memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      tag_mem[addr] <= {key_dev, key_sec};
    end
    rd_data <= tag_mem[rd_addr];
  end

  assign rd_dev = rd_data[47:32];
  assign rd_sec = rd_data[31:0];

  assign match = scan_on && cmp_v && (rd_data == key);
  assign last  = scan_on && cmp_v && (cmp_idx == IDX'(Entries - 1));

  // Linear scan from index zero; the first match ends it.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on <= 1'b0;
      cmp_v   <= 1'b0;
      iss     <= '0;
      stat    <= '0;
    end else begin
      stat.done <= !ctl.scan && (match || last);
      if (ctl.scan) begin
        scan_on  <= 1'b1;
        iss      <= '0;
        cmp_v    <= 1'b0;
        stat.hit <= 1'b0;
      end else if (scan_on) begin
        if (iss < CW'(Entries)) begin
          iss   <= iss + CW'(1);
          cmp_v <= 1'b1;
        end else begin
          cmp_v <= 1'b0;
        end
        if (match || last) begin
          scan_on  <= 1'b0;
          stat.hit <= match;
        end
      end
    end
  end

  // Payload registers of the scan.
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      key <= {key_dev, key_sec};
    end
    cmp_idx <= iss[IDX-1:0];
    if (match || last) begin
      hit_idx <= cmp_idx;
    end
  end

  `CHK_NEXT(a_done_pulse, stat.done, !stat.done, "tag scan done held longer than a cycle")
  `CHK_NEXT(a_scan_start, ctl.scan, scan_on && !stat.done, "tag scan failed to start")
  `CHK_IMPL(a_iss_bound, scan_on, iss <= CW'(Entries), "tag scan ran past the last entry")

endmodule

`default_nettype wire

### hw/rtl/sector_buffer_cache_directory.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_stall | sbcd_pkg::req_t
// rsp     | out       | rsp_valid/rsp_stall | sbcd_pkg::rsp_t
//
// One request is worked on at a time; the next is taken once the previous
// word sits in the response register, even while that word is stalled.
// get/read run a tag scan, then one LRU pass; a release that frees an entry
// runs three LRU passes.
// Pass lengths are set by the single read port of the tag and LRU memories.
// After reset a clearing pass over every entry runs before a request is taken.
`default_nettype none
`include "assert_macros.svh"

module sector_buffer_cache_directory #(
  parameter int Entries   = sbcd_pkg::DEF_ENTRIES,
  parameter int CountBits = sbcd_pkg::DEF_COUNT_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sbcd_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sbcd_pkg::rsp_t rsp
);

  localparam int IDX = $clog2(Entries);
  localparam int CW  = IDX + 1;
  localparam int EW  = (CW > 7) ? CW : 7;
  localparam int MW  = CountBits + 2;
  localparam logic [IDX-1:0] LAST = IDX'(Entries - 1);
  localparam logic [CountBits-1:0] CMAX = {CountBits{1'b1}};

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_MHIT  = 4'd4;
  localparam logic [3:0] S_MMISS = 4'd5;
  localparam logic [3:0] S_MREL  = 4'd6;
  localparam logic [3:0] S_RM    = 4'd7;
  localparam logic [3:0] S_TAIL  = 4'd8;
  localparam logic [3:0] S_FF    = 4'd9;
  localparam logic [3:0] S_INS   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]     state;
  sbcd_pkg::req_t it;
  sbcd_pkg::rsp_t res;
  logic [IDX-1:0] b;
  logic [CW-1:0]  cnt;
  logic           dv;
  logic [IDX-1:0] dj;
  logic           found;
  logic           to_free;
  logic           v1;
  logic           v2;
  logic [IDX-1:0] i1;
  logic [IDX-1:0] i2;
  logic [IDX-1:0] carry;

  // Metadata memory: {count, valid, dirty}.
  logic [MW-1:0]  meta_mem [Entries];
  logic [MW-1:0]  meta_rdata;
  logic           meta_we;
  logic [IDX-1:0] meta_waddr;
  logic [MW-1:0]  meta_wdata;
  logic [IDX-1:0] meta_raddr;

  // LRU order memory, head at index zero.
  logic [IDX-1:0] lru_mem [Entries];
  logic [IDX-1:0] lru_rdata;
  logic           lru_we;
  logic [IDX-1:0] lru_waddr;
  logic [IDX-1:0] lru_wdata;
  logic [IDX-1:0] lru_raddr;

  sbcd_pkg::tag_ctl_t  tctl;
  sbcd_pkg::tag_stat_t tstat;
  logic [IDX-1:0]      taddr;
  logic [IDX-1:0]      thit_idx;
  logic [15:0]         tkey_dev;
  logic [31:0]         tkey_sec;
  logic [15:0]         trd_dev;
  logic [31:0]         trd_sec;

  logic [CountBits-1:0] m_cnt;
  logic                 m_v;
  logic                 m_d;
  logic [CountBits-1:0] cnt_inc;
  logic                 in_range;
  logic                 is_lookup;

  assign m_cnt   = meta_rdata[MW-1:2];
  assign m_v     = meta_rdata[1];
  assign m_d     = meta_rdata[0];
  assign cnt_inc = (m_cnt == CMAX) ? m_cnt : m_cnt + CountBits'(1);

  assign in_range  = EW'(req.entry) < EW'(Entries);
  assign is_lookup = (req.func == sbcd_pkg::FN_GET) || (req.func == sbcd_pkg::FN_READ);
  assign req_stall = (state != S_IDLE);

  sbcd_tags #(
    .Entries(Entries)
  ) u_tags (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tctl),
    .key_dev (tkey_dev),
    .key_sec (tkey_sec),
    .addr    (taddr),
    .stat    (tstat),
    .hit_idx (thit_idx),
    .rd_dev  (trd_dev),
    .rd_sec  (trd_sec)
  );

  // Memories.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_raddr];
    if (lru_we) begin
      lru_mem[lru_waddr] <= lru_wdata;
    end
    lru_rdata <= lru_mem[lru_raddr];
  end

  // Memory and tag store port control per state.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = b;
    meta_wdata = '0;
    meta_raddr = b;
    lru_we     = 1'b0;
    lru_waddr  = dj - IDX'(1);
    lru_wdata  = lru_rdata;
    lru_raddr  = cnt[IDX-1:0];
    tctl       = '0;
    taddr      = b;
    tkey_dev   = it.device;
    tkey_sec   = it.sector;
    unique case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = cnt[IDX-1:0];
        lru_we     = 1'b1;
        lru_waddr  = cnt[IDX-1:0];
        lru_wdata  = cnt[IDX-1:0];
        tctl.wr    = 1'b1;
        taddr      = cnt[IDX-1:0];
        tkey_dev   = '0;
        tkey_sec   = '0;
      end
      S_IDLE: begin
        meta_raddr = IDX'(req.entry);
        taddr      = IDX'(req.entry);
        tkey_dev   = req.device;
        tkey_sec   = req.sector;
        tctl.scan  = req_valid && is_lookup && req.size_ok;
      end
      S_SCAN: begin
        meta_raddr = thit_idx;
        lru_raddr  = '0;
      end
      S_HEAD: begin
        meta_raddr = lru_rdata;
      end
      S_MHIT: begin
        meta_we    = 1'b1;
        meta_wdata = {cnt_inc, m_v, m_d};
      end
      S_MMISS: begin
        if (m_cnt == '0) begin
          meta_we    = 1'b1;
          meta_wdata = {CountBits'(1), 1'b0, 1'b0};
          tctl.wr    = 1'b1;
        end
      end
      S_MREL: begin
        if (it.func == sbcd_pkg::FN_READ_DONE && it.io_ok) begin
          meta_we    = 1'b1;
          meta_wdata = {m_cnt, 1'b1, 1'b0};
        end else if (it.func == sbcd_pkg::FN_MARK_DIRTY) begin
          meta_we    = 1'b1;
          meta_wdata = {m_cnt, m_v, 1'b1};
        end else if (m_cnt != '0) begin
          meta_we    = 1'b1;
          meta_wdata = {m_cnt - CountBits'(1), m_v,
                        (m_cnt == CountBits'(1)) ? (m_d && !m_v) : m_d};
        end
      end
      S_RM: begin
        lru_we = dv && found;
      end
      S_TAIL: begin
        lru_we    = 1'b1;
        lru_waddr = LAST;
        lru_wdata = b;
      end
      S_FF: begin
        meta_raddr = lru_rdata;
      end
      S_INS: begin
        lru_we    = dv;
        lru_waddr = dj;
        lru_wdata = carry;
      end
      default: begin
      end
    endcase
  end

  // Response valid: set as a finished word is loaded, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      dv        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      found     <= 1'b0;
      to_free   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt[IDX-1:0] == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            it <= req;
            b  <= IDX'(req.entry);
            if (is_lookup) begin
              if (!req.size_ok) begin
                res   <= '{status: sbcd_pkg::ST_SIZE, default: '0};
                state <= S_DONE;
              end else begin
                res   <= '0;
                state <= S_SCAN;
              end
            end else if (req.func == sbcd_pkg::FN_READ_DONE
                         || req.func == sbcd_pkg::FN_RELEASE
                         || req.func == sbcd_pkg::FN_MARK_DIRTY) begin
              res   <= '{slot: req.entry, default: '0};
              state <= in_range ? S_MREL : S_DONE;
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (tstat.done) begin
            if (tstat.hit) begin
              b     <= thit_idx;
              state <= S_MHIT;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          b     <= lru_rdata;
          state <= S_MMISS;
        end
        S_MHIT: begin
          res.slot <= 7'(b);
          if (it.func == sbcd_pkg::FN_READ && !m_v) begin
            res.read_request <= 1'b1;
            res.io_device    <= it.device;
            res.io_sector    <= it.sector;
          end
          cnt     <= '0;
          dv      <= 1'b0;
          found   <= 1'b0;
          to_free <= 1'b0;
          state   <= S_RM;
        end
        S_MMISS: begin
          res.slot <= 7'(b);
          if (m_cnt != '0) begin
            res.status <= sbcd_pkg::ST_BUSY;
            state      <= S_DONE;
          end else begin
            res.fresh <= 1'b1;
            if (it.func == sbcd_pkg::FN_READ) begin
              res.read_request <= 1'b1;
              res.io_device    <= it.device;
              res.io_sector    <= it.sector;
            end
            cnt     <= '0;
            dv      <= 1'b0;
            found   <= 1'b0;
            to_free <= 1'b0;
            state   <= S_RM;
          end
        end
        S_MREL: begin
          if ((it.func == sbcd_pkg::FN_READ_DONE && it.io_ok)
              || it.func == sbcd_pkg::FN_MARK_DIRTY) begin
            state <= S_DONE;
          end else begin
            if (it.func == sbcd_pkg::FN_READ_DONE) begin
              res.status <= sbcd_pkg::ST_READ_FAIL;
            end
            if (m_cnt == CountBits'(1)) begin
              // Last reference dropped: free the entry.
              res.wake_waiters <= 1'b1;
              if (m_v && m_d) begin
                res.write_request <= 1'b1;
                res.io_device     <= trd_dev;
                res.io_sector     <= trd_sec;
              end
              cnt     <= '0;
              dv      <= 1'b0;
              found   <= 1'b0;
              to_free <= 1'b1;
              state   <= S_RM;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RM: begin
          // Remove b from the order, closing the gap towards the head.
          dj <= cnt[IDX-1:0];
          if (dv && lru_rdata == b) begin
            found <= 1'b1;
          end
          if (dv && dj == LAST) begin
            dv    <= 1'b0;
            cnt   <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
            state <= to_free ? S_FF : S_TAIL;
          end else if (cnt < CW'(Entries)) begin
            cnt <= cnt + CW'(1);
            dv  <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
        end
        S_TAIL: begin
          state <= S_DONE;
        end
        S_FF: begin
          // Find the first in-use entry among the first Entries-1 places.
          i1 <= cnt[IDX-1:0];
          v2 <= v1;
          i2 <= i1;
          if (v2 && (m_cnt != '0 || i2 == IDX'(Entries - 2))) begin
            cnt   <= (m_cnt != '0) ? CW'(i2) : CW'(LAST);
            dv    <= 1'b0;
            carry <= b;
            state <= S_INS;
          end else if (cnt < CW'(Entries - 1)) begin
            cnt <= cnt + CW'(1);
            v1  <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
        end
        S_INS: begin
          // Shift towards the tail from the insert place, b going in first.
          dj <= cnt[IDX-1:0];
          if (dv) begin
            carry <= lru_rdata;
          end
          if (dv && dj == LAST) begin
            dv    <= 1'b0;
            state <= S_DONE;
          end else if (cnt <= CW'(Entries - 1)) begin
            cnt <= cnt + CW'(1);
            dv  <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Response word register.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  `CHK_NEXT(a_rsp_src, !rsp_valid && state != S_DONE, !rsp_valid, "response without a finished request")
  `CHK_IMPL(a_wake_clean, rsp_valid && rsp.wake_waiters, !rsp.fresh && !rsp.read_request, "wake word carries lookup flags")
  `CHK_IMPL(a_hit_count, state == S_MHIT && meta_we, meta_wdata[MW-1:2] != '0, "hit left a zero count")
  `CHK_IMPL(a_lru_member, state == S_RM && dv && dj == LAST, found || lru_rdata == b, "entry missing from LRU order")
  `CHK_IMPL(a_lru_range, lru_we, lru_waddr <= LAST, "LRU write beyond the last place")

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int NBUF = sbcd_pkg::DEF_ENTRIES;
  localparam int CNT_MAX = (1 << sbcd_pkg::DEF_COUNT_BITS) - 1;
  localparam int RANDOM_WORDS = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  sbcd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  sbcd_pkg::rsp_t rsp;

  sector_buffer_cache_directory dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the directory state.
  logic [15:0] dir_dev [NBUF];
  logic [31:0] dir_sec [NBUF];
  int unsigned dir_cnt [NBUF];
  logic dir_valid [NBUF];
  logic dir_dirty [NBUF];
  logic [6:0] dir_lru [NBUF];

  sbcd_pkg::req_t pending_words[$];
  sbcd_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int words_in = 0;
  int busy_seen = 0;
  int writebacks_seen = 0;
  int reads_seen = 0;

  // Take buffer b out of the LRU order, leaving the last place open.
  function automatic void lru_take_out(input logic [6:0] b);
    int p;
    p = NBUF - 1;
    for (int i = 0; i < NBUF; i++) begin
      if (dir_lru[i] == b) begin
        p = i;
        break;
      end
    end
    for (int i = p; i < NBUF - 1; i++) dir_lru[i] = dir_lru[i + 1];
  endfunction

  // Put b just ahead of the first buffer that is still referenced.
  function automatic void lru_park_free(input logic [6:0] b);
    int p;
    lru_take_out(b);
    p = NBUF - 1;
    for (int i = 0; i < NBUF - 1; i++) begin
      if (dir_cnt[dir_lru[i]] != 0) begin
        p = i;
        break;
      end
    end
    for (int i = NBUF - 1; i > p; i--) dir_lru[i] = dir_lru[i - 1];
    dir_lru[p] = b;
  endfunction

  function automatic void drop_reference(input logic [6:0] b, inout sbcd_pkg::rsp_t r);
    if (dir_cnt[b] != 0) begin
      dir_cnt[b]--;
      if (dir_cnt[b] == 0) begin
        lru_park_free(b);
        if (dir_valid[b] && dir_dirty[b]) begin
          dir_dirty[b] = 1'b0;
          r.write_request = 1'b1;
          r.io_device = dir_dev[b];
          r.io_sector = dir_sec[b];
        end
        r.wake_waiters = 1'b1;
      end
    end
  endfunction

  // Work out the response word for one request and update the shadow state.
  function automatic sbcd_pkg::rsp_t directory_answer(input sbcd_pkg::req_t q);
    sbcd_pkg::rsp_t r;
    logic hit;
    logic [6:0] b;
    r = '0;
    hit = 1'b0;
    b = '0;
    if (q.func == sbcd_pkg::FN_GET || q.func == sbcd_pkg::FN_READ) begin
      if (!q.size_ok) begin
        r.status = sbcd_pkg::ST_SIZE;
        return r;
      end
      for (int i = 0; i < NBUF; i++) begin
        if (dir_dev[i] == q.device && dir_sec[i] == q.sector) begin
          b = 7'(i);
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        if (dir_cnt[b] < CNT_MAX) dir_cnt[b]++;
      end else begin
        b = dir_lru[0];
        if (dir_cnt[b] != 0) begin
          r.status = sbcd_pkg::ST_BUSY;
          r.slot = b;
          return r;
        end
        dir_cnt[b] = 1;
        dir_dev[b] = q.device;
        dir_sec[b] = q.sector;
        dir_valid[b] = 1'b0;
        dir_dirty[b] = 1'b0;
        r.fresh = 1'b1;
      end
      lru_take_out(b);
      dir_lru[NBUF - 1] = b;
      r.slot = b;
      if (q.func == sbcd_pkg::FN_READ && !dir_valid[b]) begin
        r.read_request = 1'b1;
        r.io_device = dir_dev[b];
        r.io_sector = dir_sec[b];
      end
      return r;
    end
    if (q.func > sbcd_pkg::FN_MARK_DIRTY) return r;
    r.slot = q.entry;
    case (q.func)
      sbcd_pkg::FN_READ_DONE: begin
        if (q.io_ok) begin
          dir_valid[q.entry] = 1'b1;
          dir_dirty[q.entry] = 1'b0;
        end else begin
          r.status = sbcd_pkg::ST_READ_FAIL;
          drop_reference(q.entry, r);
        end
      end
      sbcd_pkg::FN_RELEASE: drop_reference(q.entry, r);
      default: dir_dirty[q.entry] = 1'b1;
    endcase
    return r;
  endfunction

  function automatic sbcd_pkg::req_t make_word(input logic [2:0] f, input logic [15:0] d,
                                               input logic [31:0] s, input logic ok,
                                               input logic [6:0] e, input logic io);
    sbcd_pkg::req_t q;
    q.func = f;
    q.device = d;
    q.sector = s;
    q.size_ok = ok;
    q.entry = e;
    q.io_ok = io;
    return q;
  endfunction

  // Sender: bursts of words separated by random gaps; the model is updated
  // on each accepted word.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    sbcd_pkg::rsp_t r;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        r = directory_answer(req);
        expected_rsps.push_back(r);
        words_in++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          req <= pending_words.pop_front();
          req_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall behaviour rotates among three modes: none, light and heavy.
  int cyc = 0;
  always @(posedge clk) begin
    sbcd_pkg::rsp_t e;
    cyc++;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp.status == sbcd_pkg::ST_BUSY) busy_seen++;
        if (rsp.write_request) writebacks_seen++;
        if (rsp.read_request) reads_seen++;
        if (expected_rsps.size() == 0) begin
          $error("response word with nothing expected");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp != e) begin
            errors++;
            if (rsp.status != e.status)
              $error("status exp %0h got %0h", e.status, rsp.status);
            if (rsp.slot != e.slot)
              $error("slot exp %0h got %0h", e.slot, rsp.slot);
            if (rsp.fresh != e.fresh)
              $error("fresh exp %0h got %0h", e.fresh, rsp.fresh);
            if (rsp.read_request != e.read_request)
              $error("read_request exp %0h got %0h", e.read_request, rsp.read_request);
            if (rsp.write_request != e.write_request)
              $error("write_request exp %0h got %0h", e.write_request, rsp.write_request);
            if (rsp.io_device != e.io_device)
              $error("io_device exp %0h got %0h", e.io_device, rsp.io_device);
            if (rsp.io_sector != e.io_sector)
              $error("io_sector exp %0h got %0h", e.io_sector, rsp.io_sector);
            if (rsp.wake_waiters != e.wake_waiters)
              $error("wake_waiters exp %0h got %0h", e.wake_waiters, rsp.wake_waiters);
          end
        end
      end
    end
    case ((cyc / 3000) % 3)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 2) == 0);
      default: rsp_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Pick a buffer that is likely to be held, for releases and completions.
  function automatic logic [6:0] held_entry();
    logic [6:0] start;
    start = 7'($urandom_range(0, NBUF - 1));
    for (int i = 0; i < NBUF; i++) begin
      if (dir_cnt[(start + i) % NBUF] != 0) return 7'((start + i) % NBUF);
    end
    return start;
  endfunction

  task automatic queue_random_word();
    int pick;
    logic [15:0] d;
    logic [31:0] s;
    logic [2:0] f;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      d = 16'($urandom);
      s = $urandom;
    end else begin
      d = 16'($urandom_range(0, 3));
      s = $urandom_range(0, 15);
      if (d == 3) d = 16'hFFFF;
      if (s == 15) s = 32'hFFFF_FFFF;
    end
    if (pick < 30) f = sbcd_pkg::FN_GET;
    else if (pick < 55) f = sbcd_pkg::FN_READ;
    else if (pick < 67) f = sbcd_pkg::FN_READ_DONE;
    else if (pick < 92) f = sbcd_pkg::FN_RELEASE;
    else if (pick < 98) f = sbcd_pkg::FN_MARK_DIRTY;
    else f = 3'($urandom_range(5, 7));
    pending_words.push_back(make_word(f, d, s, $urandom_range(0, 19) != 0,
                            ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                        : held_entry(),
                            $urandom_range(0, 3) != 0));
  endtask

  initial begin
    for (int i = 0; i < NBUF; i++) begin
      dir_dev[i] = '0;
      dir_sec[i] = '0;
      dir_cnt[i] = 0;
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      dir_lru[i] = 7'(i);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words: all-zero tag hit, refused size, extremes, read paths,
    // failed completion, write-back on release, release of a free buffer.
    pending_words.push_back(make_word(sbcd_pkg::FN_GET, 16'h0, 32'h0, 1'b1, 7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_READ, 16'h1, 32'h2, 1'b0, 7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_GET, 16'hFFFF, 32'hFFFF_FFFF, 1'b0,
                                      7'd127, 1'b1));
    pending_words.push_back(make_word(sbcd_pkg::FN_GET, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                      7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                                      7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_READ_DONE, 16'h0, 32'h0, 1'b1, 7'd1, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_READ_DONE, 16'h0, 32'h0, 1'b1, 7'd1, 1'b1));
    pending_words.push_back(make_word(sbcd_pkg::FN_MARK_DIRTY, 16'h0, 32'h0, 1'b1, 7'd1, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1, 7'd1, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1, 7'd1, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_READ, 16'h0, 32'h0, 1'b1, 7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1, 7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1, 7'd0, 1'b0));
    pending_words.push_back(make_word(3'd5, 16'h0, 32'h0, 1'b1, 7'd3, 1'b1));
    pending_words.push_back(make_word(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 7'd127, 1'b1));
    pending_words.push_back(make_word(3'd7, 16'h0, 32'h0, 1'b0, 7'd0, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_MARK_DIRTY, 16'h0, 32'h0, 1'b1,
                                      7'd127, 1'b0));
    pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1,
                                      7'd127, 1'b1));
    pending_words.push_back(make_word(sbcd_pkg::FN_READ, 16'h1234, 32'h55AA_55AA, 1'b1,
                                      7'd0, 1'b0));

    // Fill every buffer so that the next miss finds a busy head, then free them.
    for (int i = 0; i <= NBUF; i++)
      pending_words.push_back(make_word(sbcd_pkg::FN_GET, 16'h00B0, 32'(i), 1'b1,
                                        7'd0, 1'b0));
    for (int i = 0; i < NBUF; i++)
      pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1,
                                        7'(i), 1'b0));

    // Drive one count into saturation and all the way back down.
    while (pending_words.size() > 0) @(posedge clk);
    for (int i = 0; i < CNT_MAX + 2; i++)
      pending_words.push_back(make_word(sbcd_pkg::FN_GET, 16'h0005, 32'h5, 1'b1,
                                        7'd0, 1'b0));
    while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    for (int i = 0; i < CNT_MAX + 1; i++)
      pending_words.push_back(make_word(sbcd_pkg::FN_RELEASE, 16'h0, 32'h0, 1'b1,
                                        held_entry(), 1'b0));

    // Random traffic, generated a little ahead of the sender.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      while (pending_words.size() >= 2) @(posedge clk);
      queue_random_word();
    end

    while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Accepted %0d request words: %0d busy answers, %0d read requests,",
             words_in, busy_seen, reads_seen);
    $display("%0d write-backs; count saturation and a full directory were covered.",
             writebacks_seen);
    if (errors == 0) begin
      $display("sector_buffer_cache_directory: match");
    end else begin
      $display("sector_buffer_cache_directory: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60ms;
    $display("sector_buffer_cache_directory: mismatch");
    $finish;
  end

endmodule
